// ===== design/vdz_pkg.sv =====
`default_nettype none

package vdz_pkg;

  localparam int DIST_W = 16;
  localparam int CLASS_W = 3;
  localparam int SIGMA_W = 20;
  localparam int BROAD_W = 10;
  localparam int DEF_TABLE_INDEX_BITS = 8;
  localparam logic [BROAD_W-1:0] BROAD_RESET = 10'd20;
  localparam logic [CLASS_W-1:0] LAST_CLASS = 3'd5;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_m;
    logic [CLASS_W-1:0] class_code;
  } item_t;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma_z_q8;
    logic               class_error;
  } result_t;

  function automatic logic [21:0] coef_a(input logic [CLASS_W-1:0] cls);
    case (cls)
      3'd0: coef_a = 22'd2046820;
      3'd1: coef_a = 22'd2181038;
      3'd2: coef_a = 22'd1879048;
      3'd3: coef_a = 22'd1644167;
      3'd4: coef_a = 22'd1021732;
      3'd5: coef_a = 22'd1070386;
      default: coef_a = '0;
    endcase
  endfunction

  function automatic logic [16:0] coef_b(input logic [CLASS_W-1:0] cls);
    case (cls)
      3'd0: coef_b = 17'd69468;
      3'd1: coef_b = 17'd62259;
      3'd2: coef_b = 17'd60293;
      3'd3: coef_b = 17'd58262;
      3'd4: coef_b = 17'd58655;
      3'd5: coef_b = 17'd51315;
      default: coef_b = '0;
    endcase
  endfunction

  function automatic logic [15:0] coef_c(input logic [CLASS_W-1:0] cls);
    case (cls)
      3'd0: coef_c = 16'd9026;
      3'd1: coef_c = 16'd10939;
      3'd2: coef_c = 16'd15183;
      3'd3: coef_c = 16'd22649;
      3'd4: coef_c = 16'd32883;
      3'd5: coef_c = 16'd22817;
      default: coef_c = '0;
    endcase
  endfunction

  function automatic logic [16:0] coef_d(input logic [CLASS_W-1:0] cls);
    case (cls)
      3'd0: coef_d = 17'd53412;
      3'd1: coef_d = 17'd49152;
      3'd2: coef_d = 17'd47055;
      3'd3: coef_d = 17'd45089;
      3'd4: coef_d = 17'd44827;
      3'd5: coef_d = 17'd44040;
      default: coef_d = '0;
    endcase
  endfunction

  // elaboration-time only, builds rom contents
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] vv;
    res = '0;
    vv = v;
    bt = 64'd1 << 62;
    while (bt > vv) bt = bt >> 2;
    while (bt != 0) begin
      if (vv >= res + bt) begin
        vv = vv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [16:0] log_entry(input int i, input int bits);
    logic [63:0] y;
    logic [16:0] r;
    r = '0;
    y = ONE_Q30 + (64'(i) << (30 - bits));
    if (i == (1 << bits)) return 17'd65536;
    for (int k = 1; k <= 16; k++) begin
      y = (y * y) >> 30;
      if (y >= 2 * ONE_Q30) begin
        y = y >> 1;
        r[16-k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] exp_entry(input int i, input int bits);
    logic [63:0] roots [13];
    logic [63:0] acc;
    for (int k = 0; k < 13; k++) roots[k] = '0;
    if (i == (1 << bits)) return 32'h8000_0000;
    roots[0] = 2 * ONE_Q30;
    for (int k = 1; k <= bits; k++) roots[k] = isqrt64(roots[k-1] << 30);
    acc = ONE_Q30;
    for (int k = 0; k < bits; k++)
      if (((i >> k) & 1) != 0) acc = (acc * roots[bits-k]) >> 30;
    return 32'(acc);
  endfunction

endpackage

`default_nettype wire

// ===== design/vertical_dispersion_sigma_z.sv =====
`default_nettype none

// channel  | dir | handshake            | payload
// item     | in  | item_valid/stall     | distance_m, class_code
// result   | out | result_valid/stall   | sigma_z_q8, class_error
// cfg      | in  | cfg_valid/cfg_ready  | initial broadening, meters
//
// one request per cycle while item_stall is low; pipeline stages: log, exponent, power, product,
// divider setup, 21 divider stages, square, sum, 22 square root stages, output register
// rst clears stage valids and sets the broadening register to 20
// each stage moves when its successor is empty or moving, so bubbles close up
// and a stalled result holds while earlier stages keep filling
module vertical_dispersion_sigma_z #(
  parameter int TABLE_INDEX_BITS = vdz_pkg::DEF_TABLE_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  vdz_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output vdz_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vdz_pkg::BROAD_W-1:0]   cfg_data
);
  import vdz_pkg::*;

  localparam int TIB = TABLE_INDEX_BITS;
  localparam int TAB_SIZE = (1 << TIB) + 1;
  localparam int LSH = 15 - TIB;
  localparam int ESH = 16 - TIB;
  localparam int DIV_BITS = 21;
  localparam int SQRT_BITS = 22;
  localparam int ST_DIV = 5;
  localparam int ST_SQ = ST_DIV + DIV_BITS;
  localparam int ST_SUM = ST_SQ + 1;
  localparam int ST_SQRT = ST_SUM + 1;
  localparam int ST_OUT = ST_SQRT + SQRT_BITS;
  localparam int NST = ST_OUT + 1;

  typedef struct packed {
    logic               err;
    logic               zero;
    logic [CLASS_W-1:0] cls;
  } meta_t;

  logic [16:0] log_rom [TAB_SIZE];
  logic [31:0] exp_rom [TAB_SIZE];

  for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_rom
    assign log_rom[gi] = log_entry(gi, TIB);
    assign exp_rom[gi] = exp_entry(gi, TIB);
  end

  logic [BROAD_W-1:0] broad;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      broad <= BROAD_RESET;
    end else if (cfg_valid) begin
      broad <= cfg_data;
    end
  end

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  meta_t          meta [NST];

  assign rdy[NST] = !result_stall;
  for (genvar gk = 0; gk < NST; gk++) begin : g_rdy
    assign rdy[gk] = !vld[gk] || rdy[gk+1];
  end
  assign item_stall = !rdy[0];
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= item_valid;
      for (int k = 1; k < NST; k++)
        if (rdy[k]) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      meta[0].err <= item.class_code > LAST_CLASS;
      meta[0].zero <= item.distance_m == '0;
      meta[0].cls <= item.class_code;
    end
    for (int k = 1; k < NST; k++)
      if (rdy[k]) meta[k] <= meta[k-1];
  end

  // log2 of distance
  logic [3:0]        lexp;
  logic [30:0]       xs;
  logic [TIB-1:0]    lidx;
  logic [LSH-1:0]    lrem;
  logic [16:0]       llo, lhi, ldiff;
  logic [16+LSH:0]   lprod;
  logic [20:0]       l_next, l_q;

  always_comb begin
    lexp = '0;
    for (int b = 0; b < DIST_W; b++)
      if (item.distance_m[b]) lexp = 4'(b);
    xs = {15'd0, item.distance_m} << (4'd15 - lexp);
    lidx = xs[14:LSH];
    lrem = xs[LSH-1:0];
    llo = log_rom[{1'b0, lidx}];
    lhi = log_rom[{1'b0, lidx} + 1'b1];
    ldiff = (lhi > llo) ? lhi - llo : '0;
    lprod = (17 + LSH)'(ldiff) * (17 + LSH)'(lrem);
    l_next = {1'b0, lexp, 16'd0} + 21'(llo) + 21'(lprod >> LSH);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) l_q <= l_next;
  end

  // exponents for b and d
  logic [20:0] t_q [2];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t_q[0] <= 21'((38'(l_q) * 38'(coef_b(meta[0].cls))) >> 16);
      t_q[1] <= 21'((38'(l_q) * 38'(coef_d(meta[0].cls))) >> 16);
    end
  end

  // exp2 mantissa
  logic [ESH-1:0]  erem [2];
  logic [TIB-1:0]  eidx [2];
  logic [31:0]     elo [2], ehi [2], ediff [2], m_next [2], m_q [2];
  logic [31+ESH:0] eprod [2];
  logic [4:0]      n_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      eidx[i] = t_q[i][15:ESH];
      erem[i] = t_q[i][ESH-1:0];
      elo[i] = exp_rom[{1'b0, eidx[i]}];
      ehi[i] = exp_rom[{1'b0, eidx[i]} + 1'b1];
      ediff[i] = (ehi[i] > elo[i]) ? ehi[i] - elo[i] : '0;
      eprod[i] = (32 + ESH)'(ediff[i]) * (32 + ESH)'(erem[i]);
      m_next[i] = elo[i] + 32'(eprod[i] >> ESH);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 2; i++) begin
        m_q[i] <= m_next[i];
        n_q[i] <= t_q[i][20:16];
      end
    end
  end

  // a*x^b and c*x^d
  logic [33:0] pb, pd;
  logic [55:0] num_q;
  logic [49:0] cpd_q;

  always_comb begin
    pb = 34'((64'(m_q[0]) << n_q[0]) >> 14);
    pd = 34'((64'(m_q[1]) << n_q[1]) >> 14);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      num_q <= 56'(coef_a(meta[2].cls)) * 56'(pb);
      cpd_q <= 50'(coef_c(meta[2].cls)) * 50'(pd);
    end
  end

  // restoring divider, one quotient bit per stage
  logic [63:0] rem_q [DIV_BITS+1];
  logic [50:0] den_q [DIV_BITS+1];
  logic [20:0] quo_q [DIV_BITS+1];
  logic        ovf_q [DIV_BITS+1];
  logic [50:0] den_next;

  assign den_next = (51'd1 << 40) + 51'(cpd_q);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rem_q[0] <= {num_q, 8'd0};
      den_q[0] <= den_next;
      quo_q[0] <= '0;
      ovf_q[0] <= 51'(num_q >> 13) >= den_next;
    end
  end

  for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_div
    localparam int K = DIV_BITS - 1 - gj;
    logic [71:0] trial;
    logic        take;
    assign trial = 72'(den_q[gj]) << K;
    assign take = 72'(rem_q[gj]) >= trial;
    always_ff @(posedge clk) begin
      if (rdy[ST_DIV+gj]) begin
        rem_q[gj+1] <= take ? 64'(72'(rem_q[gj]) - trial) : rem_q[gj];
        den_q[gj+1] <= den_q[gj];
        quo_q[gj+1] <= quo_q[gj] | (take ? (21'd1 << K) : 21'd0);
        ovf_q[gj+1] <= ovf_q[gj];
      end
    end
  end

  // clamp and square both terms
  logic [20:0] sig;
  logic [17:0] bq;
  logic [41:0] ss_q;
  logic [35:0] bb_q;

  always_comb begin
    if (meta[ST_SQ-1].zero) begin
      sig = '0;
    end else if (ovf_q[DIV_BITS] || quo_q[DIV_BITS] > 21'h10_0000) begin
      sig = 21'h10_0000;
    end else begin
      sig = quo_q[DIV_BITS];
    end
    bq = {broad, 8'd0};
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_SQ]) begin
      ss_q <= 42'(sig) * 42'(sig);
      bb_q <= 36'(bq) * 36'(bq);
    end
  end

  // square root, one result bit per stage
  logic [43:0] sv_q [SQRT_BITS+1];
  logic [43:0] sr_q [SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      sv_q[0] <= 44'(ss_q) + 44'(bb_q);
      sr_q[0] <= '0;
    end
  end

  for (genvar gs = 0; gs < SQRT_BITS; gs++) begin : g_sqrt
    localparam int I = SQRT_BITS - 1 - gs;
    logic [43:0] bt;
    logic        take;
    assign bt = 44'd1 << (2 * I);
    assign take = sv_q[gs] >= sr_q[gs] + bt;
    always_ff @(posedge clk) begin
      if (rdy[ST_SQRT+gs]) begin
        sv_q[gs+1] <= take ? sv_q[gs] - (sr_q[gs] + bt) : sv_q[gs];
        sr_q[gs+1] <= take ? (sr_q[gs] >> 1) + bt : sr_q[gs] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      if (meta[ST_OUT-1].err) begin
        result.sigma_z_q8 <= '0;
        result.class_error <= 1'b1;
      end else begin
        result.sigma_z_q8 <= (sr_q[SQRT_BITS] > 44'(20'hF_FFFF)) ? 20'hF_FFFF
                             : sr_q[SQRT_BITS][19:0];
        result.class_error <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_vertical_dispersion_sigma_z.sv =====
module tb_vertical_dispersion_sigma_z;
  timeunit 1ns;
  timeprecision 1ps;
  import vdz_pkg::*;

  localparam int TIB = DEF_TABLE_INDEX_BITS;
  localparam int NTAB = (1 << TIB) + 1;
  localparam int LATENCY = 51;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BROAD_W-1:0] cfg_data = '0;

  vertical_dispersion_sigma_z u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  longint log2_rom [NTAB];
  longint exp2_rom [NTAB];
  logic [BROAD_W-1:0] broadening_m = BROAD_RESET;
  result_t sigma_expected [$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  localparam longint A_Q24 [6] = '{2046820, 2181038, 1879048, 1644167, 1021732, 1070386};
  localparam longint B_Q16 [6] = '{69468, 62259, 60293, 58262, 58655, 51315};
  localparam longint C_Q24 [6] = '{9026, 10939, 15183, 22649, 32883, 22817};
  localparam longint D_Q16 [6] = '{53412, 49152, 47055, 45089, 44827, 44040};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic build_roms();
    longint unsigned roots [TIB+1];
    longint unsigned y, acc;
    longint r;
    roots[0] = 2 * (64'd1 << 30);
    for (int k = 1; k <= TIB; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < (1 << TIB); i++) begin
      y = (64'd1 << 30) + (longint'(i) << (30 - TIB));
      acc = 64'd1 << 30;
      r = 0;
      for (int k = 1; k <= 16; k++) begin
        y = (y * y) >> 30;
        if (y >= 2 * (64'd1 << 30)) begin
          y = y >> 1;
          r = r | (longint'(1) << (16 - k));
        end
      end
      log2_rom[i] = r;
      for (int k = 0; k < TIB; k++)
        if ((i >> k) & 1) acc = (acc * roots[TIB-k]) >> 30;
      exp2_rom[i] = acc;
    end
    log2_rom[1 << TIB] = 65536;
    exp2_rom[1 << TIB] = 2 * (64'd1 << 30);
  endtask

  function automatic longint unsigned log2_of(int unsigned x);
    int unsigned e, f, idx, rem, sh;
    longint unsigned lo, hi, diff;
    sh = 15 - TIB;
    e = 15;
    while (e > 0 && ((x >> e) & 1) == 0) e--;
    f = (x << (15 - e)) & 32'h7fff;
    idx = f >> sh;
    rem = f & ((1 << sh) - 1);
    lo = log2_rom[idx];
    hi = log2_rom[idx+1];
    diff = hi > lo ? hi - lo : 0;
    return (longint'(e) << 16) + lo + ((diff * rem) >> sh);
  endfunction

  function automatic longint unsigned exp2_of(longint unsigned t);
    int unsigned n, f, sh, idx, rem;
    longint unsigned lo, hi, diff, m;
    n = 32'((t >> 16) & 64'd31);
    f = 32'(t & 64'hffff);
    sh = 16 - TIB;
    idx = f >> sh;
    rem = f & ((1 << sh) - 1);
    lo = exp2_rom[idx];
    hi = exp2_rom[idx+1];
    diff = hi > lo ? hi - lo : 0;
    m = lo + ((diff * rem) >> sh);
    return (m << n) >> 14;
  endfunction

  function automatic result_t sigma_z_of(item_t it);
    result_t o;
    longint unsigned sig, l, pb, pd, num, den, bq, rs;
    int c;
    o = '0;
    c = it.class_code;
    if (it.class_code > LAST_CLASS) begin
      o.class_error = 1'b1;
      return o;
    end
    sig = 0;
    if (it.distance_m != 0) begin
      l = log2_of(it.distance_m);
      pb = exp2_of((l * B_Q16[c]) >> 16);
      pd = exp2_of((l * D_Q16[c]) >> 16);
      num = A_Q24[c] * pb;
      den = (64'd1 << 40) + C_Q24[c] * pd;
      sig = (num << 8) / den;
      if (sig > (64'd1 << 20)) sig = 64'd1 << 20;
    end
    bq = longint'(broadening_m) << 8;
    rs = int_sqrt(sig * sig + bq * bq);
    if (rs > 1048575) rs = 1048575;
    o.sigma_z_q8 = rs[SIGMA_W-1:0];
    return o;
  endfunction

  task automatic send_request(logic [DIST_W-1:0] d, logic [CLASS_W-1:0] c);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{distance_m: d, class_code: c};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sigma_expected = {sigma_expected, sigma_z_of('{distance_m: d, class_code: c})};
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sigma_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_broadening(logic [BROAD_W-1:0] b);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    broadening_m = b;
  endtask

  function automatic logic [DIST_W-1:0] rand_distance();
    case ($urandom_range(3, 0))
      0: return DIST_W'($urandom_range(100, 0));
      1: return DIST_W'($urandom_range(5000, 0));
      default: return DIST_W'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic [DIST_W-1:0] dists [6] = '{16'd0, 16'd1, 16'd2, 16'd1000, 16'd32768, 16'hffff};
    for (int c = 0; c < 8; c++) send_request(dists[c % 6], CLASS_W'(c));
    for (int i = 0; i < 6; i++) send_request(dists[i], 3'd0);
    for (int i = 0; i < 6; i++) send_request(dists[i], 3'd5);
    send_request(16'hffff, 3'd7);
    send_request(16'h5555, 3'd6);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_request(rand_distance(),
                   $urandom_range(9, 0) == 0 ? CLASS_W'($urandom_range(7, 6))
                                             : CLASS_W'($urandom_range(5, 0)));
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    test_random(90);
  endtask

  task automatic test_broadening_settings();
    write_broadening(10'd0);
    send_request(16'd0, 3'd2);
    test_random(60);
    write_broadening(10'd1023);
    send_request(16'd0, 3'd1);
    send_request(16'hffff, 3'd0);
    test_random(60);
    write_broadening(BROAD_W'($urandom_range(1023, 0)));
    test_random(60);
    write_broadening(BROAD_RESET);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (sigma_expected.size() == 0) begin
        $error("unexpected result %h", result);
        failures++;
      end else begin
        exp_r = sigma_expected.pop_front();
        if (result.sigma_z_q8 !== exp_r.sigma_z_q8) begin
          $error("sigma_z_q8 expected %0d actual %0d", exp_r.sigma_z_q8, result.sigma_z_q8);
          failures++;
        end
        if (result.class_error !== exp_r.class_error) begin
          $error("class_error expected %0d actual %0d", exp_r.class_error,
                 result.class_error);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_vertical_dispersion_sigma_z NOT OK");
      $finish;
    end
  end

  initial begin
    build_roms();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 58;
    test_directed();
    test_random(150);
    test_backpressure();
    send_idle_pct = 58;
    recv_idle_pct = 6;
    test_broadening_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    drain();
    if (failures == 0 && sigma_expected.size() == 0)
      $display("tb_vertical_dispersion_sigma_z OK");
    else
      $display("tb_vertical_dispersion_sigma_z NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/vdz_pkg.sv
design/vertical_dispersion_sigma_z.sv
tb/tb_vertical_dispersion_sigma_z.sv
